>>> sv/frcn_pkg.sv
// shared types and constants for the frame relative change norm block
package frcn_pkg;

    localparam int VALUE_W = 24;
    localparam int SUM_W   = 61;
    localparam int ERR_W   = 24;
    localparam int CFG_W   = 13;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_a;
        logic signed [VALUE_W-1:0] value_b;
    } in_item_t;

    typedef struct packed {
        logic [ERR_W-1:0] error_a;
        logic [ERR_W-1:0] error_b;
        logic             zero_norm_a;
        logic             zero_norm_b;
    } out_item_t;

    // frame totals handed from the accumulator to the norm unit
    typedef struct packed {
        logic [SUM_W-1:0] square_a;
        logic [SUM_W-1:0] square_b;
        logic [SUM_W-1:0] change_a;
        logic [SUM_W-1:0] change_b;
    } frame_sums_t;

    // saturating add of two unsigned sums
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                  input logic [SUM_W-1:0] v);
        logic [SUM_W:0] r;
        begin
            r = {1'b0, s} + {1'b0, v};
            sat_add = r[SUM_W] ? SUM_MAX : r[SUM_W-1:0];
        end
    endfunction

endpackage

>>> sv/frcn_ram.sv
// generic single port ram with registered read
module frcn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> sv/frcn_front.sv
// front part: cell memory, clearing pass, squares and frame sums
module frcn_front #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  frcn_pkg::in_item_t         in_data,
    input  logic [frcn_pkg::CFG_W-1:0] cells_in_use,
    output logic                       sums_valid,
    input  logic                       sums_full,
    output frcn_pkg::frame_sums_t      sums
);
    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int PW = $clog2(MAX_CELLS + 1);
    localparam int CW = (PW > frcn_pkg::CFG_W) ? PW : frcn_pkg::CFG_W;
    localparam int VW = frcn_pkg::VALUE_W;
    localparam int SW = frcn_pkg::SUM_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_ACC   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      clr_reg;
    logic               clr_done_reg;
    frcn_pkg::in_item_t item_reg;
    frcn_pkg::frame_sums_t acc_reg, acc_next;
    logic [VW-1:0]      prev_a, prev_b;
    logic               we;
    logic [AW-1:0]      addr;
    logic [CW-1:0]      count;
    logic [CW:0]        pos_plus;
    logic [2*VW-1:0]    sq_a, sq_b;
    logic signed [VW:0] df_a, df_b;
    logic [2*VW+1:0]    dq_a, dq_b;
    logic               last_cell;
    logic               is_clear;

    assign is_clear = (state_reg == ST_CLEAR);
    assign in_stall = (state_reg != ST_IDLE);
    // outside the clearing pass, the cell is written only in the cycle it leaves the accumulate step
    assign we       = is_clear || ((state_reg == ST_ACC) && !(last_cell && sums_full));
    assign addr     = is_clear ? clr_reg : pos_reg;

    frcn_ram #(.WIDTH(VW), .DEPTH(MAX_CELLS)) u_prev_a (
        .clk(clk), .we(we), .addr(addr),
        .wdata(is_clear ? '0 : item_reg.value_a), .rdata(prev_a));
    frcn_ram #(.WIDTH(VW), .DEPTH(MAX_CELLS)) u_prev_b (
        .clk(clk), .we(we), .addr(addr),
        .wdata(is_clear ? '0 : item_reg.value_b), .rdata(prev_b));

    // effective frame length, clamped to 1..MAX_CELLS
    always_comb
    begin
        count = CW'(cells_in_use);
        if (count == '0)
        begin
            count = CW'(1);
        end
        if (count > CW'(MAX_CELLS))
        begin
            count = CW'(MAX_CELLS);
        end
        pos_plus  = {1'b0, CW'(pos_reg)} + (CW+1)'(1);
        last_cell = (pos_plus >= {1'b0, count});
    end

    always_comb
    begin
        sq_a = (2*VW)'($unsigned(item_reg.value_a < 0 ? -item_reg.value_a
                                                      : item_reg.value_a));
        sq_a = sq_a * sq_a;
        sq_b = (2*VW)'($unsigned(item_reg.value_b < 0 ? -item_reg.value_b
                                                      : item_reg.value_b));
        sq_b = sq_b * sq_b;
        df_a = {item_reg.value_a[VW-1], item_reg.value_a}
             - {prev_a[VW-1], prev_a};
        df_b = {item_reg.value_b[VW-1], item_reg.value_b}
             - {prev_b[VW-1], prev_b};
        dq_a = (2*VW+2)'($unsigned(df_a < 0 ? -df_a : df_a));
        dq_a = dq_a * dq_a;
        dq_b = (2*VW+2)'($unsigned(df_b < 0 ? -df_b : df_b));
        dq_b = dq_b * dq_b;
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                // a frame end waits for room in the queue
                if (!(last_cell && sums_full))
                begin
                    acc_next.square_a = frcn_pkg::sat_add(acc_reg.square_a, SW'(sq_a));
                    acc_next.square_b = frcn_pkg::sat_add(acc_reg.square_b, SW'(sq_b));
                    acc_next.change_a = frcn_pkg::sat_add(acc_reg.change_a, SW'(dq_a));
                    acc_next.change_b = frcn_pkg::sat_add(acc_reg.change_b, SW'(dq_b));
                    state_next = ST_IDLE;
                    pos_next   = last_cell ? '0 : AW'(pos_plus);
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign sums_valid = (state_reg == ST_ACC) && last_cell && !sums_full;
    assign sums       = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pos_reg      <= '0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (is_clear && !clr_done_reg)
            begin
                clr_reg <= clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_CELLS - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (state_reg == ST_ACC && state_next == ST_IDLE)
            begin
                acc_reg <= last_cell ? '0 : acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
    end
endmodule

>>> sv/frcn_back.sv
// back part: frame sum queue, serial divide and square root per field
module frcn_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sums_valid,
    output logic                  sums_full,
    input  frcn_pkg::frame_sums_t sums,
    output logic                  out_valid,
    input  logic                  out_stall,
    output frcn_pkg::out_item_t   out_data
);
    localparam int SW = frcn_pkg::SUM_W;
    localparam int QW = 64;
    localparam int EW = frcn_pkg::ERR_W;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_LOAD = 6'b000010,
        B_DIV  = 6'b000100,
        B_SQRT = 6'b001000,
        B_NEXT = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    // two-entry queue of frame totals
    frcn_pkg::frame_sums_t q_reg [2];
    logic                  wp_reg, rp_reg;
    logic [1:0]            cnt_reg;

    bstate_t          st_reg;
    logic             fld_reg;
    logic [SW-1:0]    s_reg;
    logic [SW+1:0]    r_reg;
    logic [QW-1:0]    q_reg2;
    logic [6:0]       n_reg;
    logic [QW-1:0]    x_reg, res_reg, bit_reg;
    logic [EW-1:0]    err_a_reg, err_b_reg, err_val;
    logic             zn_a_reg, zn_b_reg, sat_flag;
    frcn_pkg::frame_sums_t head;
    logic [SW-1:0]    d_in, s_in;
    logic [SW+1:0]    r_sh;
    logic [QW-1:0]    trial;
    logic             pop;

    assign sums_full = (cnt_reg == 2'd2);
    assign head      = q_reg[rp_reg];
    assign d_in      = fld_reg ? head.change_b : head.change_a;
    assign s_in      = fld_reg ? head.square_b : head.square_a;
    assign r_sh      = {r_reg[SW:0], 1'b0};
    assign trial     = res_reg + bit_reg;
    assign pop       = (st_reg == B_NEXT) && fld_reg;
    assign out_valid = (st_reg == B_OUT);
    assign out_data  = '{error_a: err_a_reg, error_b: err_b_reg,
                         zero_norm_a: zn_a_reg, zero_norm_b: zn_b_reg};
    assign err_val   = (sat_flag || res_reg > QW'(frcn_pkg::ERR_MAX))
                       ? frcn_pkg::ERR_MAX : res_reg[EW-1:0];

    always_ff @(posedge clk)
    begin
        if (sums_valid)
        begin
            q_reg[wp_reg] <= sums;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            cnt_reg  <= '0;
            st_reg   <= B_IDLE;
            fld_reg  <= 1'b0;
            sat_flag <= 1'b0;
        end
        else
        begin
            if (sums_valid)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(sums_valid) - 2'(pop);
            unique case (st_reg)
                B_IDLE:
                begin
                    if (cnt_reg != '0)
                    begin
                        st_reg  <= B_LOAD;
                        fld_reg <= 1'b0;
                    end
                end
                B_LOAD:
                begin
                    // quotient d/s taken with 32 fraction bits, bit-serially
                    s_reg    <= s_in;
                    r_reg    <= '0;
                    q_reg2   <= '0;
                    x_reg    <= {3'b0, d_in};
                    n_reg    <= 7'd95;
                    sat_flag <= (s_in == '0) || ((d_in >> 16) >= s_in);
                    st_reg   <= B_DIV;
                end
                B_DIV:
                begin
                    if ((r_sh | (SW+2)'(x_reg[QW-1])) >= {2'b0, s_reg})
                    begin
                        r_reg  <= (r_sh | (SW+2)'(x_reg[QW-1])) - {2'b0, s_reg};
                        q_reg2 <= {q_reg2[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg  <= r_sh | (SW+2)'(x_reg[QW-1]);
                        q_reg2 <= {q_reg2[QW-2:0], 1'b0};
                    end
                    x_reg <= {x_reg[QW-2:0], 1'b0};
                    if (n_reg == 7'd0)
                    begin
                        st_reg  <= B_SQRT;
                        res_reg <= '0;
                        bit_reg <= QW'(1) << (QW - 2);
                        n_reg   <= 7'd32;
                    end
                    else
                    begin
                        n_reg <= n_reg - 7'd1;
                    end
                end
                B_SQRT:
                begin
                    // restoring square root, two bits of radicand a step
                    if (n_reg == 7'd32)
                    begin
                        x_reg <= q_reg2;
                    end
                    else if (x_reg >= trial)
                    begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                        bit_reg <= bit_reg >> 2;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                    n_reg <= n_reg - 7'd1;
                    if (n_reg == 7'd0)
                    begin
                        st_reg <= B_NEXT;
                    end
                end
                B_NEXT:
                begin
                    if (!fld_reg)
                    begin
                        err_a_reg <= (s_reg == '0) ? '0 : err_val;
                        zn_a_reg  <= (s_reg == '0);
                        fld_reg   <= 1'b1;
                        st_reg    <= B_LOAD;
                    end
                    else
                    begin
                        err_b_reg <= (s_reg == '0) ? '0 : err_val;
                        zn_b_reg  <= (s_reg == '0);
                        st_reg    <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (!out_stall)
                    begin
                        st_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule

>>> sv/frame_relative_change_norm.sv
// top level of the frame relative change norm block
// front part: a cell is taken while idle, then passes the memory read and accumulate steps
// the front part takes no new cell until it is through with the last one
// frame end: load, divide, root and next steps run for field a, then for field b
// reset: a clearing pass over all MAX_CELLS cells zeroes the previous frame store,
// no cell is taken during it; cells_in_use resets to 4
module frame_relative_change_norm #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // cell input channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  frcn_pkg::in_item_t       in_data,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output frcn_pkg::out_item_t      out_data,
    // frame length register write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [frcn_pkg::CFG_W-1:0] cfg_data
);
    logic [frcn_pkg::CFG_W-1:0] cells_reg;
    logic                       sums_valid;
    logic                       sums_full;
    frcn_pkg::frame_sums_t      sums;

    // register write always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= frcn_pkg::CFG_W'(4);
        end
        else if (cfg_valid)
        begin
            cells_reg <= cfg_data;
        end
    end

    // front: per cell transfer into the frame sums
    frcn_front #(.MAX_CELLS(MAX_CELLS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .cells_in_use(cells_reg),
        .sums_valid(sums_valid), .sums_full(sums_full), .sums(sums));

    // back: per frame norms
    frcn_back u_back (
        .clk(clk), .rst_n(rst_n),
        .sums_valid(sums_valid), .sums_full(sums_full), .sums(sums),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
endmodule
